>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/ptoe_pkg.sv
// ----------------------------------------------------------------------------
// ptoe_pkg
// shared types and constants of the peer table
// ----------------------------------------------------------------------------
package ptoe_pkg;

	localparam int MAX_PEERS = 32;
	localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam int ADDR_W    = 48;
	localparam int FREQ_W    = 17;
	localparam int TIME_W    = 32;
	localparam int SEQ_W     = 32;
	localparam int SLOT_W    = 5;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SEQ_W-1:0]  seq_t;

	// one table entry as stored in memory
	typedef struct packed {
		addr_t addr;
		time_t seen_at;
		freq_t freq;
		seq_t  seq;
	} entry_t;

	// outcome of one full scan
	typedef struct packed {
		logic  hit;
		idx_t  hit_idx;
		seq_t  hit_seq;
		logic  free;
		idx_t  free_idx;
		idx_t  vic_idx;
		addr_t vic_addr;
	} scan_res_t;

endpackage

>>> hw/rtl/peer_table_oldest_eviction.sv
// ----------------------------------------------------------------------------
// peer_table_oldest_eviction
// peer table searched by address, oldest-entry replacement on a full miss
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | mac_addr, frequency, now
//  out     | out_valid/out_ready| was_present, slot, evicted, evicted_addr
//
// an item goes through accepting, one memory read per entry, draining the read
// pipe and writing back; the entry memory has a single read port, so the
// entries are read one at a time.
// reset clears the valid bits and the insertion counter; no clearing pass.
// a waiting result does not block the next item from being accepted; only the
// write-back cycle waits for the output register to free up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module peer_table_oldest_eviction (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [47:0]           mac_addr,
	input  logic [16:0]           frequency,
	input  logic [31:0]           now,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  was_present,
	output logic [4:0]            slot,
	output logic                  evicted,
	output logic [47:0]           evicted_addr
);
	import ptoe_pkg::*;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t state_q;

	// latched item
	addr_t addr_q;
	freq_t freq_q;
	time_t now_q;

	// table bookkeeping kept in flops
	logic [MAX_PEERS-1:0] valid_q;
	seq_t                 seq_q;
	idx_t                 idx_q;

	// read pipe stage
	logic act_s1;
	logic vld_s1;
	idx_t idx_s1;

	// output register
	logic          out_valid_q;
	logic          was_present_q;
	logic [SLOT_W-1:0] slot_q;
	logic          evicted_q;
	addr_t         evicted_addr_q;

	entry_t    rd_data;
	entry_t    wr_data;
	scan_res_t res;
	idx_t      fin_idx;
	logic      full_miss;
	logic      in_acc;
	logic      wr_go;
	logic      scan_rd;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign scan_rd  = (state_q == ST_SCAN);

	// write back only once the output register can take the result
	assign wr_go = (state_q == ST_WRITE) && (!out_valid_q || out_ready);

	assign full_miss = !res.hit && !res.free;

	always_comb begin
		if (res.hit) begin
			fin_idx = res.hit_idx;
		end else if (res.free) begin
			fin_idx = res.free_idx;
		end else begin
			fin_idx = res.vic_idx;
		end
	end

	// hit keeps the address and insertion order, a miss takes a fresh number
	assign wr_data.addr    = addr_q;
	assign wr_data.seen_at = now_q;
	assign wr_data.freq    = freq_q;
	assign wr_data.seq     = res.hit ? res.hit_seq : seq_q;

	ptoe_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_go),
		.wr_idx  (fin_idx),
		.wr_data (wr_data),
		.rd_en   (scan_rd),
		.rd_idx  (idx_q),
		.rd_data (rd_data)
	);

	ptoe_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc),
		.act       (act_s1),
		.idx       (idx_s1),
		.ent_valid (vld_s1),
		.ent       (rd_data),
		.key       (addr_q),
		.res       (res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_W'(MAX_PEERS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (wr_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= mac_addr;
			freq_q <= frequency;
			now_q  <= now;
		end
	end

	// read pipe: valid bit lines up with the memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		vld_s1 <= valid_q[idx_q];
	end

	// valid bits and insertion counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seq_q   <= '0;
		end else if (wr_go && !res.hit) begin
			valid_q[fin_idx] <= 1'b1;
			seq_q            <= seq_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			was_present_q  <= res.hit;
			slot_q         <= SLOT_W'(fin_idx);
			evicted_q      <= full_miss;
			evicted_addr_q <= full_miss ? res.vic_addr : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign was_present  = was_present_q;
	assign slot         = slot_q;
	assign evicted      = evicted_q;
	assign evicted_addr = evicted_addr_q;

	// eviction happens only on a miss into a full table
	`ASSERT_IMPLY(a_evict_full, clk, arst_n, wr_go && full_miss, &valid_q)
	// an evicting result never reports a hit
	`ASSERT_IMPLY(a_evict_miss, clk, arst_n, out_valid_q, !(evicted_q && was_present_q))
	// an accepted item always starts a scan from the first entry
	`ASSERT_NEXT(a_start_scan, clk, arst_n, in_acc, state_q == ST_SCAN && idx_q == '0)
	// a free slot reported by the scan is really free
	`ASSERT_IMPLY(a_free_slot, clk, arst_n, wr_go && !res.hit && res.free, !valid_q[res.free_idx])

endmodule

>>> hw/rtl/ptoe_mem.sv
// ----------------------------------------------------------------------------
// ptoe_mem
// entry memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module ptoe_mem (
	input  logic            clk,
	input  logic            wr_en,
	input  ptoe_pkg::idx_t   wr_idx,
	input  ptoe_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  ptoe_pkg::idx_t   rd_idx,
	output ptoe_pkg::entry_t rd_data
);
	import ptoe_pkg::*;

	entry_t mem [MAX_PEERS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

>>> hw/rtl/ptoe_scan.sv
// ----------------------------------------------------------------------------
// ptoe_scan
// per-entry match, free-slot and oldest-entry tracking over one scan
// ----------------------------------------------------------------------------
module ptoe_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               act,
	input  ptoe_pkg::idx_t      idx,
	input  logic               ent_valid,
	input  ptoe_pkg::entry_t    ent,
	input  ptoe_pkg::addr_t     key,
	output ptoe_pkg::scan_res_t res
);
	import ptoe_pkg::*;

	logic  hit_q, free_q, vic_found_q;
	idx_t  hit_idx_q, free_idx_q, vic_idx_q;
	seq_t  hit_seq_q, vic_seq_q;
	addr_t vic_addr_q;
	time_t vic_time_q;
	logic  older;

	// strictly older, or same age and inserted later
	assign older = !vic_found_q || (ent.seen_at < vic_time_q) ||
		((ent.seen_at == vic_time_q) && (ent.seq > vic_seq_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			vic_found_q <= 1'b0;
		end else if (start) begin
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			vic_found_q <= 1'b0;
		end else if (act) begin
			if (!ent_valid) begin
				if (!free_q) begin
					free_q <= 1'b1;
				end
			end else begin
				if (ent.addr == key && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (older) begin
					vic_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act && !start) begin
			if (!ent_valid) begin
				if (!free_q) begin
					free_idx_q <= idx;
				end
			end else begin
				if (ent.addr == key && !hit_q) begin
					hit_idx_q <= idx;
					hit_seq_q <= ent.seq;
				end
				if (older) begin
					vic_idx_q  <= idx;
					vic_addr_q <= ent.addr;
					vic_time_q <= ent.seen_at;
					vic_seq_q  <= ent.seq;
				end
			end
		end
	end

	assign res.hit      = hit_q;
	assign res.hit_idx  = hit_idx_q;
	assign res.hit_seq  = hit_seq_q;
	assign res.free     = free_q;
	assign res.free_idx = free_idx_q;
	assign res.vic_idx  = vic_idx_q;
	assign res.vic_addr = vic_addr_q;

endmodule

>>> dv/peer_table_oldest_eviction_chk.sv
// ----------------------------------------------------------------------------
// peer_table_oldest_eviction_chk
// watches both channels, keeps its own copy of the peer table, predicts the
// outcome of every accepted sighting and compares it with each result item
// ----------------------------------------------------------------------------
module peer_table_oldest_eviction_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [47:0]       mac_addr,
	input  logic [16:0]       frequency,
	input  logic [31:0]       now,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              was_present,
	input  logic [4:0]        slot,
	input  logic              evicted,
	input  logic [47:0]       evicted_addr,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);
	import ptoe_pkg::*;

	typedef struct {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		addr_t             gone_addr;
	} outcome_t;

	logic        tbl_valid [MAX_PEERS];
	addr_t       tbl_addr  [MAX_PEERS];
	time_t       tbl_seen  [MAX_PEERS];
	freq_t       tbl_freq  [MAX_PEERS];
	seq_t        tbl_seq   [MAX_PEERS];
	seq_t        insert_count;
	outcome_t    outcome_q [$];
	int unsigned fails;

	// scan, pick hit / free slot / oldest entry, then update the table
	function automatic outcome_t record_sighting(addr_t addr, freq_t freq, time_t ts);
		int       hit_idx;
		int       free_idx;
		int       oldest;
		int       idx;
		outcome_t res;
		hit_idx  = -1;
		free_idx = -1;
		oldest   = -1;
		res      = '{hit: 1'b0, slot: '0, evicted: 1'b0, gone_addr: '0};
		for (int i = 0; i < MAX_PEERS; i++) begin
			if (!tbl_valid[i]) begin
				if (free_idx < 0)
					free_idx = i;
			end else begin
				if (tbl_addr[i] == addr && hit_idx < 0)
					hit_idx = i;
				// unsigned age compare, ties go to the later insertion
				if (oldest < 0 || tbl_seen[i] < tbl_seen[oldest] ||
				    (tbl_seen[i] == tbl_seen[oldest] && tbl_seq[i] > tbl_seq[oldest]))
					oldest = i;
			end
		end
		if (hit_idx >= 0) begin
			idx     = hit_idx;
			res.hit = 1'b1;
		end else begin
			if (free_idx >= 0) begin
				idx = free_idx;
			end else begin
				idx           = oldest;
				res.evicted   = 1'b1;
				res.gone_addr = tbl_addr[oldest];
			end
			tbl_valid[idx] = 1'b1;
			tbl_addr[idx]  = addr;
			tbl_seq[idx]   = insert_count;
			insert_count   = insert_count + 1'b1;
		end
		tbl_seen[idx] = ts;
		tbl_freq[idx] = freq;
		res.slot      = idx[SLOT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_PEERS; i++)
				tbl_valid[i] = 1'b0;
			insert_count = '0;
			outcome_q.delete();
			fails = 0;
		end else begin
			// result side first: a result never belongs to the item taken this edge
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result item with no sighting pending");
					fails++;
				end else begin
					want = outcome_q.pop_front();
					if (was_present !== want.hit) begin
						$error("was_present: expected %0d, got %0d", want.hit, was_present);
						fails++;
					end
					if (slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, slot);
						fails++;
					end
					if (evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, evicted);
						fails++;
					end
					if (evicted_addr !== want.gone_addr) begin
						$error("evicted_addr: expected %h, got %h", want.gone_addr,
							evicted_addr);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				outcome_q.push_back(record_sighting(mac_addr, frequency, now));
		end
		mismatches  <= fails;
		outstanding <= outcome_q.size();
	end

endmodule

>>> dv/peer_table_oldest_eviction_tb.sv
// ----------------------------------------------------------------------------
// peer_table_oldest_eviction_tb
// drives peer sightings into the table and lets the checker score every
// result; directed corner cases first, then random sightings drawn mostly
// from a small address pool so hits, fills and evictions all happen
// ----------------------------------------------------------------------------
module peer_table_oldest_eviction_tb;
	import ptoe_pkg::*;

	localparam int ITEMS       = 500;
	localparam int POOL        = 40;       // a few more peers than slots, forces evictions
	localparam int HOLD_CYCLES = 600;      // long receiver hold-off
	localparam int DRAIN       = 3 * (MAX_PEERS + 3);
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [47:0] mac_addr;
	logic [16:0] frequency;
	logic [31:0] now;
	logic        out_valid;
	logic        out_ready;
	logic        was_present;
	logic [4:0]  slot;
	logic        evicted;
	logic [47:0] evicted_addr;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned items_sent  = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	peer_table_oldest_eviction dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mac_addr     (mac_addr),
		.frequency    (frequency),
		.now          (now),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_present  (was_present),
		.slot         (slot),
		.evicted      (evicted),
		.evicted_addr (evicted_addr)
	);

	peer_table_oldest_eviction_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mac_addr     (mac_addr),
		.frequency    (frequency),
		.now          (now),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_present  (was_present),
		.slot         (slot),
		.evicted      (evicted),
		.evicted_addr (evicted_addr),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs or drops a result
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("peer_table_oldest_eviction_tb: FAIL");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold-off in the middle
	// of the run so the output register backs up and in_ready drops
	initial begin : receiver
		bit long_hold_done;
		long_hold_done = 1'b0;
		out_ready      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && items_sent >= 250) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				// sender keeps offering items all through this stretch
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// offer one sighting item; valid and payload stay put until accepted
	task automatic send_sighting(input addr_t addr, input freq_t freq, input time_t ts);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		mac_addr  <= addr;
		frequency <= freq;
		now       <= ts;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	initial begin : stimulus
		addr_t pool [POOL];
		addr_t addr;
		time_t stamp;
		int    pick;
		int    bit_pos;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mac_addr  = '0;
		frequency = '0;
		now       = '0;

		for (int i = 0; i < POOL; i++)
			pool[i] = addr_t'({$urandom(), $urandom()});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first phase: sender idles a little, receiver a lot
		tx_idle_pct = 16;
		rx_idle_pct = 73;

		// directed: address and field extremes, hits, equal times, time going
		// backwards, and the largest timestamp
		send_sighting(48'h0, 17'h0, 32'h0);                          // first slot
		send_sighting(48'hFFFF_FFFF_FFFF, 17'h1FFFF, 32'h0);         // next free slot
		send_sighting(48'h0, 17'h0ABCD, 32'h1);                      // hit
		send_sighting(48'hAAAA_AAAA_AAAA, 17'h15555, 32'h1);
		send_sighting(48'h5555_5555_5555, 17'h0AAAA, 32'h1);         // same time, tie
		send_sighting(48'hFFFF_FFFF_FFFF, 17'h00001, 32'h2);         // hit on all-ones
		send_sighting(48'hFFFF_FFFF_FFFE, 17'h10000, 32'h2);         // one bit off a stored peer
		send_sighting(48'h0000_0000_0001, 17'h1FFFF, 32'h2);         // one bit off address zero
		send_sighting(48'h0, 17'h00000, 32'h0);                      // hit with an earlier time
		send_sighting(48'hAAAA_AAAA_AAAA, 17'h1FFFF, 32'hFFFF_FFFF); // largest time
		send_sighting(48'h8000_0000_0000, 17'h0FFFF, 32'h8000_0000);
		send_sighting(48'h5555_5555_5555, 17'h00000, 32'h0000_0003); // hit, time drops

		// random part: mostly pooled peers with a slowly moving clock, so the
		// table fills and many entries share a timestamp; some fresh addresses,
		// near-miss addresses, big time jumps and time going backwards
		stamp = 32'h10;
		for (int n = 0; n < ITEMS; n++) begin
			if (n == ITEMS / 3) begin
				tx_idle_pct = 73;
				rx_idle_pct = 16;
			end else if (n == 2 * ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			pick = $urandom_range(99);
			if (pick < 78) begin
				addr = pool[$urandom_range(POOL - 1)];
			end else if (pick < 88) begin
				bit_pos = $urandom_range(47);
				addr    = pool[$urandom_range(POOL - 1)];
				addr[bit_pos] = ~addr[bit_pos];
			end else begin
				addr = addr_t'({$urandom(), $urandom()});
			end

			pick = $urandom_range(99);
			if (pick < 45)
				stamp = stamp;                              // equal times, ties
			else if (pick < 85)
				stamp = stamp + $urandom_range(1, 4);
			else if (pick < 95)
				stamp = stamp + $urandom();                 // big jump, may wrap
			else
				stamp = stamp - $urandom_range(1, 50);      // out of order

			send_sighting(addr, freq_t'($urandom_range(131071)), stamp);
		end
		in_valid <= 1'b0;

		// wait out every pending result, then a few scans for stray extras
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0)
			$display("peer_table_oldest_eviction_tb: PASS");
		else
			$display("peer_table_oldest_eviction_tb: FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ptoe_pkg.sv
hw/rtl/ptoe_mem.sv
hw/rtl/ptoe_scan.sv
hw/rtl/peer_table_oldest_eviction.sv
dv/peer_table_oldest_eviction_chk.sv
dv/peer_table_oldest_eviction_tb.sv
